// ----- src/pps_pkg.sv -----
// pps_pkg: shared constants for the preemptive priority scheduler
// request codes, fixed result field widths and parameter defaults
// no dependencies
package pps_pkg;

    // fixed widths of the transaction fields
    localparam int REQ_W  = 2;
    localparam int TIME_W = 20;
    localparam int SLOT_W = 4;

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // parameter defaults
    localparam int MAX_PROCS_DEF  = 16;
    localparam int BURST_BITS_DEF = 16;
    localparam int PRIO_BITS_DEF  = 8;

endpackage

// ----- src/pps_table.sv -----
// pps_table: process table memory, one write port and one read port
// read data is registered and appears the cycle after rd_en; no dependencies
module pps_table #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 40
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/preemptive_priority_scheduler.sv -----
// preemptive_priority_scheduler: top level, request decode, table scan and update
// depends on pps_pkg and pps_table
//
//   channel | direction | ports                                          | handshake
//   s_      | in        | s_req_type, s_burst, s_prio                    | s_valid/s_ready
//   m_      | out       | m_ran_valid, m_ran_slot, m_finished,           | m_valid/m_ready
//           |           | m_finish_at, m_waiting, m_turnaround           |
//
// Load and clear transactions give no result. During a tick the single read
// port of the table is swept one slot per cycle over the loaded slots, then
// the chosen slot is written back; an idle tick on an empty table skips the
// sweep and goes straight to the result. Reset clears the control state
// and the slot count; the table contents need no clearing. A tick result waits
// in the output register while m_ready is low; the next transaction is still
// taken, and a following tick holds in its last cycle until the register frees.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS  = pps_pkg::MAX_PROCS_DEF,
    parameter int BURST_BITS = pps_pkg::BURST_BITS_DEF,
    parameter int PRIO_BITS  = pps_pkg::PRIO_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [pps_pkg::REQ_W-1:0]   s_req_type,
    input  logic [BURST_BITS-1:0]       s_burst,
    input  logic [PRIO_BITS-1:0]        s_prio,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_ran_valid,
    output logic [pps_pkg::SLOT_W-1:0]  m_ran_slot,
    output logic                        m_finished,
    output logic [pps_pkg::TIME_W-1:0]  m_finish_at,
    output logic [pps_pkg::TIME_W-1:0]  m_waiting,
    output logic [pps_pkg::TIME_W-1:0]  m_turnaround
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int ENT_W = 2 * BURST_BITS + PRIO_BITS;
    localparam int TW    = pps_pkg::TIME_W;
    localparam int CMP_W = (BURST_BITS > TW) ? BURST_BITS : TW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [TW-1:0]               time_reg, time_next;
    logic [IDX_W-1:0]            ev_idx_reg, ev_idx_next;
    logic                        found_reg, found_next;
    logic [PRIO_BITS-1:0]        best_prio_reg, best_prio_next;
    logic [IDX_W-1:0]            pick_reg, pick_next;
    logic [BURST_BITS-1:0]       pick_burst_reg, pick_burst_next;
    logic [BURST_BITS-1:0]       pick_left_reg, pick_left_next;

    logic                        m_valid_reg, m_valid_next;
    logic                        ran_valid_reg, ran_valid_next;
    logic [pps_pkg::SLOT_W-1:0]  ran_slot_reg, ran_slot_next;
    logic                        finished_reg, finished_next;
    logic [TW-1:0]               finish_at_reg, finish_at_next;
    logic [TW-1:0]               waiting_reg, waiting_next;

    // table port signals
    logic                        mem_we, mem_re;
    logic [IDX_W-1:0]            mem_waddr, mem_raddr;
    logic [ENT_W-1:0]            mem_wdata, mem_rdata;

    // fields of the entry read back
    logic [BURST_BITS-1:0]       rd_burst, rd_left;
    logic [PRIO_BITS-1:0]        rd_prio;

    logic                        out_free;
    logic                        cand;
    logic                        last_slot;
    logic [IDX_W-1:0]            ev_idx_inc;
    logic [BURST_BITS-1:0]       left_dec;
    logic [TW-1:0]               fin;
    logic [CMP_W-1:0]            fin_ext, burst_ext, wait_diff;
    logic [IDX_W+pps_pkg::SLOT_W-1:0] slot_ext;

    pps_table #(
        .DEPTH  (MAX_PROCS),
        .DATA_W (ENT_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // entry layout: {burst, prio, left}
    assign rd_left  = mem_rdata[BURST_BITS-1:0];
    assign rd_prio  = mem_rdata[BURST_BITS+PRIO_BITS-1:BURST_BITS];
    assign rd_burst = mem_rdata[ENT_W-1:BURST_BITS+PRIO_BITS];

    // scan and completion arithmetic
    assign cand       = (rd_left != '0) && (!found_reg || (rd_prio < best_prio_reg));
    assign ev_idx_inc = ev_idx_reg + IDX_W'(1);
    assign last_slot  = (({1'b0, ev_idx_reg} + CNT_W'(1)) == count_reg);
    assign left_dec   = pick_left_reg - BURST_BITS'(1);
    assign fin        = time_reg + TW'(1);
    assign fin_ext    = CMP_W'(fin);
    assign burst_ext  = CMP_W'(pick_burst_reg);
    assign wait_diff  = (burst_ext > fin_ext) ? '0 : (fin_ext - burst_ext);
    assign slot_ext   = {{pps_pkg::SLOT_W{1'b0}}, pick_reg};

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // next state, table accesses and result
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        time_next       = time_reg;
        ev_idx_next     = ev_idx_reg;
        found_next      = found_reg;
        best_prio_next  = best_prio_reg;
        pick_next       = pick_reg;
        pick_burst_next = pick_burst_reg;
        pick_left_next  = pick_left_reg;
        m_valid_next    = m_valid_reg;
        ran_valid_next  = ran_valid_reg;
        ran_slot_next   = ran_slot_reg;
        finished_next   = finished_reg;
        finish_at_next  = finish_at_reg;
        waiting_next    = waiting_reg;

        mem_we    = 1'b0;
        mem_waddr = pick_reg;
        mem_wdata = {pick_burst_reg, best_prio_reg, left_dec};
        mem_re    = 1'b0;
        mem_raddr = ev_idx_inc;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_req_type)
                        pps_pkg::REQ_LOAD: begin
                            if (count_reg < CNT_W'(MAX_PROCS)) begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[IDX_W-1:0];
                                mem_wdata  = {s_burst, s_prio, s_burst};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        pps_pkg::REQ_TICK: begin
                            found_next  = 1'b0;
                            ev_idx_next = '0;
                            if (count_reg != '0) begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                state_next = ST_SCAN;
                            end else begin
                                state_next = ST_FINISH;
                            end
                        end
                        pps_pkg::REQ_CLEAR: begin
                            count_next = '0;
                            time_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // keep the smallest priority, earliest slot wins ties
                if (cand) begin
                    found_next      = 1'b1;
                    best_prio_next  = rd_prio;
                    pick_next       = ev_idx_reg;
                    pick_burst_next = rd_burst;
                    pick_left_next  = rd_left;
                end
                if (last_slot) begin
                    state_next = ST_FINISH;
                end else begin
                    ev_idx_next = ev_idx_inc;
                    mem_re      = 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    ran_valid_next = 1'b0;
                    ran_slot_next  = '0;
                    finished_next  = 1'b0;
                    finish_at_next = '0;
                    waiting_next   = '0;
                    if (found_reg) begin
                        // run the chosen process one unit and write it back
                        mem_we         = 1'b1;
                        ran_valid_next = 1'b1;
                        ran_slot_next  = slot_ext[pps_pkg::SLOT_W-1:0];
                        time_next      = fin;
                        if (left_dec == '0) begin
                            finished_next  = 1'b1;
                            finish_at_next = fin;
                            waiting_next   = wait_diff[TW-1:0];
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            time_reg    <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            time_reg    <= time_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        ev_idx_reg     <= ev_idx_next;
        best_prio_reg  <= best_prio_next;
        pick_reg       <= pick_next;
        pick_burst_reg <= pick_burst_next;
        pick_left_reg  <= pick_left_next;
        ran_valid_reg  <= ran_valid_next;
        ran_slot_reg   <= ran_slot_next;
        finished_reg   <= finished_next;
        finish_at_reg  <= finish_at_next;
        waiting_reg    <= waiting_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_ran_valid  = ran_valid_reg;
    assign m_ran_slot   = ran_slot_reg;
    assign m_finished   = finished_reg;
    assign m_finish_at  = finish_at_reg;
    assign m_waiting    = waiting_reg;
    assign m_turnaround = finish_at_reg;

endmodule

// ----- tb/preemptive_priority_scheduler_test.sv -----
// preemptive_priority_scheduler_test: self-checking testbench for the priority scheduler
// drives load, tick, clear and unused requests with random idling on both channels
// depends on pps_pkg and preemptive_priority_scheduler
module preemptive_priority_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BW           = pps_pkg::BURST_BITS_DEF;
    localparam int          PW           = pps_pkg::PRIO_BITS_DEF;
    localparam int          SLOTS        = pps_pkg::MAX_PROCS_DEF;
    localparam int          RW           = pps_pkg::REQ_W;
    localparam int          SW           = pps_pkg::SLOT_W;
    localparam int          TW           = pps_pkg::TIME_W;
    localparam logic [RW-1:0] REQ_LOAD   = pps_pkg::REQ_LOAD;
    localparam logic [RW-1:0] REQ_TICK   = pps_pkg::REQ_TICK;
    localparam logic [RW-1:0] REQ_CLEAR  = pps_pkg::REQ_CLEAR;
    localparam logic [RW-1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT  = 300000;

    // one tick result as seen on the m_ channel
    typedef struct packed {
        logic          ran_valid;
        logic [SW-1:0] slot;
        logic          finished;
        logic [TW-1:0] finish_at;
        logic [TW-1:0] waiting;
        logic [TW-1:0] turnaround;
    } tick_result_t;

    // process table mirror plus the queue of tick outcomes still to arrive
    class sched_scoreboard;
        logic [BW-1:0]     burst_tab [SLOTS];
        logic [PW-1:0]     prio_tab  [SLOTS];
        logic [BW-1:0]     left_tab  [SLOTS];
        int unsigned       fill;
        logic [TW-1:0]     now;
        tick_result_t      outcome_q [$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       completions;

        function new();
            fill        = 0;
            now         = '0;
            mismatches  = 0;
            checked     = 0;
            completions = 0;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at result %0d: %s", checked, msg);
            mismatches++;
        endtask

        // pick the lowest priority number among unfinished slots and run it one unit
        function tick_result_t run_tick();
            tick_result_t      r;
            logic [TW-1:0]     fin;
            int                pick;
            r    = '0;
            pick = -1;
            for (int i = 0; i < fill; i++) begin
                if (left_tab[i] != '0 && (pick < 0 || prio_tab[i] < prio_tab[pick])) begin
                    pick = i;
                end
            end
            if (pick < 0) begin
                return r;
            end
            left_tab[pick] = left_tab[pick] - 1'b1;
            fin            = now + 1'b1;
            r.ran_valid    = 1'b1;
            r.slot         = pick[SW-1:0];
            if (left_tab[pick] == '0) begin
                r.finished   = 1'b1;
                r.finish_at  = fin;
                r.waiting    = (TW'(burst_tab[pick]) > fin) ? '0 : fin - TW'(burst_tab[pick]);
                r.turnaround = fin;
            end
            now = fin;
            return r;
        endfunction

        // accepted input transaction
        function void note_request(logic [RW-1:0] req, logic [BW-1:0] burst,
                                   logic [PW-1:0] prio);
            if (req == REQ_LOAD) begin
                if (fill < SLOTS) begin
                    burst_tab[fill] = burst;
                    prio_tab[fill]  = prio;
                    left_tab[fill]  = burst;
                    fill++;
                end
            end else if (req == REQ_CLEAR) begin
                fill = 0;
                now  = '0;
            end else if (req == REQ_TICK) begin
                outcome_q.push_back(run_tick());
            end
        endfunction

        task compare_field(string name, logic [TW-1:0] got, logic [TW-1:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
            end
        endtask

        // accepted result transaction against the oldest outcome
        task check_outcome(tick_result_t got);
            tick_result_t want;
            if (outcome_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, slot %0d", got.slot));
                return;
            end
            want = outcome_q.pop_front();
            compare_field("ran_valid", TW'(got.ran_valid), TW'(want.ran_valid));
            compare_field("ran_slot", TW'(got.slot), TW'(want.slot));
            compare_field("finished", TW'(got.finished), TW'(want.finished));
            compare_field("finish_at", got.finish_at, want.finish_at);
            compare_field("waiting", got.waiting, want.waiting);
            compare_field("turnaround", got.turnaround, want.turnaround);
            if (want.finished) begin
                completions++;
            end
            checked++;
        endtask
    endclass

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [RW-1:0]     s_req_type   = REQ_LOAD;
    logic [BW-1:0]     s_burst      = '0;
    logic [PW-1:0]     s_prio       = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic              m_ran_valid;
    logic [SW-1:0]     m_ran_slot;
    logic              m_finished;
    logic [TW-1:0]     m_finish_at;
    logic [TW-1:0]     m_waiting;
    logic [TW-1:0]     m_turnaround;

    sched_scoreboard sb = new();

    bit          send_steady = 1'b0;
    bit          take_steady = 1'b0;
    int unsigned effective   = 0;
    int unsigned ticks_sent  = 0;
    int unsigned cycle_count = 0;

    preemptive_priority_scheduler #(
        .MAX_PROCS  (SLOTS),
        .BURST_BITS (BW),
        .PRIO_BITS  (PW)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_burst      (s_burst),
        .s_prio       (s_prio),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ran_valid  (m_ran_valid),
        .m_ran_slot   (m_ran_slot),
        .m_finished   (m_finished),
        .m_finish_at  (m_finish_at),
        .m_waiting    (m_waiting),
        .m_turnaround (m_turnaround)
    );

    // clock
    always #4 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // one input transaction with a random lead-in gap
    task automatic send_request(input logic [RW-1:0] req, input logic [BW-1:0] burst,
                                input logic [PW-1:0] prio);
        int unsigned gap;
        gap = send_steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_burst    <= burst;
        s_prio     <= prio;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (req == REQ_TICK || req == REQ_CLEAR || (req == REQ_LOAD && sb.fill < SLOTS)) begin
            effective++;
        end
        if (req == REQ_TICK) begin
            ticks_sent++;
        end
        sb.note_request(req, burst, prio);
    endtask

    // result side: random stalls, every accepted transaction is checked
    initial begin
        tick_result_t got;
        int unsigned  gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = take_steady ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got.ran_valid  = m_ran_valid;
            got.slot       = m_ran_slot;
            got.finished   = m_finished;
            got.finish_at  = m_finish_at;
            got.waiting    = m_waiting;
            got.turnaround = m_turnaround;
            sb.check_outcome(got);
        end
    end

    // stimulus
    initial begin
        int unsigned   start_count;
        int unsigned   nloads;
        int unsigned   work;
        int unsigned   nticks;
        int unsigned   sel;
        logic [BW-1:0] b;
        logic [PW-1:0] p;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle on empty table, zero burst, priority tie, unused code
        send_request(REQ_TICK, '0, '0);
        send_request(REQ_LOAD, 16'd0, 8'd0);
        send_request(REQ_LOAD, 16'd1, 8'd255);
        send_request(REQ_LOAD, 16'd2, 8'd0);
        send_request(REQ_LOAD, 16'd1, 8'd0);
        send_request(REQ_UNUSED, 16'hffff, 8'hff);
        repeat (6) send_request(REQ_TICK, '0, '0);
        // directed: clear resets time, widest burst and priority
        send_request(REQ_CLEAR, 16'hffff, 8'hff);
        send_request(REQ_LOAD, 16'hffff, 8'hff);
        send_request(REQ_LOAD, 16'd3, 8'd128);
        repeat (4) send_request(REQ_TICK, '0, '0);
        send_request(REQ_CLEAR, '0, '0);
        send_request(REQ_TICK, '0, '0);

        // random batches: clear most of the time, load the table, tick through the work, with some noise
        start_count = effective;
        while (effective - start_count < RANDOM_ITEMS) begin
            send_steady = ($urandom_range(0, 3) == 0);
            take_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) begin
                send_request(REQ_CLEAR, BW'($urandom_range(0, 16'hffff)),
                             PW'($urandom_range(0, 255)));
            end
            nloads = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 10);
            work   = 0;
            // load phase
            for (int i = 0; i < nloads; i++) begin
                sel = $urandom_range(0, 19);
                if (sel == 0) begin
                    b = '0;
                end else if (sel == 1) begin
                    b = BW'($urandom_range(0, 16'hffff));
                end else begin
                    b = BW'($urandom_range(1, 6));
                end
                p = ($urandom_range(0, 1) == 0) ? PW'($urandom_range(0, 3))
                                                : PW'($urandom_range(0, 255));
                if (b <= 6) begin
                    work += b;
                end
                if ($urandom_range(0, 19) == 0) begin
                    send_request(REQ_UNUSED, BW'($urandom_range(0, 16'hffff)),
                                 PW'($urandom_range(0, 255)));
                end
                send_request(REQ_LOAD, b, p);
            end
            // tick phase, with loads landing mid-run and the odd early clear
            nticks = work + $urandom_range(0, 3);
            if (nticks > 80) begin
                nticks = 80;
            end
            for (int i = 0; i < nticks; i++) begin
                sel = $urandom_range(0, 59);
                if (sel < 2) begin
                    send_request(REQ_UNUSED, BW'($urandom_range(0, 16'hffff)),
                                 PW'($urandom_range(0, 255)));
                end else if (sel < 4) begin
                    send_request(REQ_LOAD, BW'($urandom_range(1, 4)),
                                 PW'($urandom_range(0, 255)));
                end else if (sel == 4) begin
                    send_request(REQ_CLEAR, '0, '0);
                end
                send_request(REQ_TICK, BW'($urandom_range(0, 16'hffff)),
                             PW'($urandom_range(0, 255)));
            end
        end
        s_valid <= 1'b0;
        take_steady = 1'b0;

        // drain, then watch for stray results
        while (sb.outcome_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d scheduler requests (%0d ticks) over %0d cycles",
                 effective, ticks_sent, cycle_count);
        $display("checked %0d tick results, %0d of them completions, %0d mismatches",
                 sb.checked, sb.completions, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
